// File: rtl/motor_position_seek_controller_unit_macros.svh
// Assertion macros used by the seek controller checker.
`ifndef MOTOR_POSITION_SEEK_CONTROLLER_UNIT_MACROS_SVH
`define MOTOR_POSITION_SEEK_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define MPSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define MPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpsc_pkg.sv
// Types and constants of the motor position seek controller.
package mpsc_pkg;

    localparam int THRESH_BITS    = 12;
    localparam int SPEED_BITS     = 7;
    localparam int COMPARE_BITS   = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [SPEED_BITS-1:0]   BRAKE_LEVEL   = 7'd110;
    localparam logic [COMPARE_BITS-1:0] COMPARE_SCALE = 11'd10;
    localparam logic [COMPARE_BITS-1:0] BRAKE_COMPARE = 11'd1100;

    localparam logic [THRESH_BITS-1:0] DEADBAND_RST   = 12'd20;
    localparam logic [THRESH_BITS-1:0] FAR_RST        = 12'd400;
    localparam logic [THRESH_BITS-1:0] NEAR_RST       = 12'd200;
    localparam logic [THRESH_BITS-1:0] BRAKE_RST      = 12'd10;
    localparam logic [SPEED_BITS-1:0]  SPD_FAST_RST   = 7'd100;
    localparam logic [SPEED_BITS-1:0]  SPD_START_RST  = 7'd50;
    localparam logic [SPEED_BITS-1:0]  SPD_MID_RST    = 7'd10;
    localparam logic [SPEED_BITS-1:0]  SPD_SLOW_RST   = 7'd5;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DEADBAND   = 3'd0,
        REG_FAR        = 3'd1,
        REG_NEAR       = 3'd2,
        REG_BRAKE      = 3'd3,
        REG_SPD_FAST   = 3'd4,
        REG_SPD_START  = 3'd5,
        REG_SPD_MID    = 3'd6,
        REG_SPD_SLOW   = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_MOVE     = 5'b00010,
        PH_SETTLE_A = 5'b00100,
        PH_SETTLE_B = 5'b01000,
        PH_SETTLE_C = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] deadband;
        logic [THRESH_BITS-1:0] far_threshold;
        logic [THRESH_BITS-1:0] near_threshold;
        logic [THRESH_BITS-1:0] brake_threshold;
        logic [SPEED_BITS-1:0]  speed_fast;
        logic [SPEED_BITS-1:0]  speed_start_slow;
        logic [SPEED_BITS-1:0]  speed_mid;
        logic [SPEED_BITS-1:0]  speed_slow;
    } cfg_t;

    typedef struct packed {
        phase_t                phase;
        dir_t                  dir;
        logic [SPEED_BITS-1:0] speed;
        logic                  left_on;
        logic                  right_on;
    } seek_state_t;

    typedef struct packed {
        logic [COMPARE_BITS-1:0] compare_value;
        logic                    left_channel_on;
        logic                    right_channel_on;
        dir_t                    drive_direction;
        logic                    busy_res;
        logic                    done_res;
    } result_t;

endpackage

// File: rtl/mpsc_if.sv
// Valid/ready channel interfaces for position beats and drive result beats.
interface mpsc_in_if #(
    parameter int POSITION_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] measured_position;
    logic [POSITION_BITS-1:0] target_position;

    modport source (output valid, output measured_position, output target_position,
                    input ready);
    modport sink   (input valid, input measured_position, input target_position,
                    output ready);
endinterface

interface mpsc_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] compare_value;
    logic        left_channel_on;
    logic        right_channel_on;
    logic [1:0]  drive_direction;
    logic        busy_res;
    logic        done_res;

    modport source (output valid, output compare_value, output left_channel_on,
                    output right_channel_on, output drive_direction, output busy_res,
                    output done_res, input ready);
    modport sink   (input valid, input compare_value, input left_channel_on,
                    input right_channel_on, input drive_direction, input busy_res,
                    input done_res, output ready);
endinterface

// File: rtl/motor_position_seek_controller_unit.sv
// Position seek controller: input register, tick logic and result register.
// A position beat passes through the input register and then the result register.
// One position beat per cycle unless the result side stalls; the tick logic is combinational.
// A stalled result holds in the result register while one more beat waits in the
// input register; input ready drops only when both are full.
// Reset clears the phase, direction, speed and channel enables and loads the
// configuration registers with their default values.
module motor_position_seek_controller_unit
    import mpsc_pkg::*;
#(
    parameter int POSITION_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    mpsc_in_if.sink                   in_ch,
    mpsc_out_if.source                out_ch,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    logic [POSITION_BITS-1:0] meas_reg;
    logic [POSITION_BITS-1:0] targ_reg;
    seek_state_t              state_reg;
    seek_state_t              state_next;
    logic                     out_valid_reg;
    result_t                  result_reg;
    result_t                  result_next;
    logic                     advance;
    logic                     in_ready;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband         <= DEADBAND_RST;
            cfg_reg.far_threshold    <= FAR_RST;
            cfg_reg.near_threshold   <= NEAR_RST;
            cfg_reg.brake_threshold  <= BRAKE_RST;
            cfg_reg.speed_fast       <= SPD_FAST_RST;
            cfg_reg.speed_start_slow <= SPD_START_RST;
            cfg_reg.speed_mid        <= SPD_MID_RST;
            cfg_reg.speed_slow       <= SPD_SLOW_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DEADBAND:  cfg_reg.deadband         <= cfg_data;
                REG_FAR:       cfg_reg.far_threshold    <= cfg_data;
                REG_NEAR:      cfg_reg.near_threshold   <= cfg_data;
                REG_BRAKE:     cfg_reg.brake_threshold  <= cfg_data;
                REG_SPD_FAST:  cfg_reg.speed_fast       <= cfg_data[SPEED_BITS-1:0];
                REG_SPD_START: cfg_reg.speed_start_slow <= cfg_data[SPEED_BITS-1:0];
                REG_SPD_MID:   cfg_reg.speed_mid        <= cfg_data[SPEED_BITS-1:0];
                REG_SPD_SLOW:  cfg_reg.speed_slow       <= cfg_data[SPEED_BITS-1:0];
                default:       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            meas_reg <= POSITION_BITS'(in_ch.measured_position);
            targ_reg <= POSITION_BITS'(in_ch.target_position);
        end
    end

    mpsc_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .meas       (meas_reg),
        .targ       (targ_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // advance the controller state once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= PH_IDLE;
            state_reg.dir      <= DIR_NONE;
            state_reg.speed    <= '0;
            state_reg.left_on  <= 1'b0;
            state_reg.right_on <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.compare_value    = result_reg.compare_value;
    assign out_ch.left_channel_on  = result_reg.left_channel_on;
    assign out_ch.right_channel_on = result_reg.right_channel_on;
    assign out_ch.drive_direction  = result_reg.drive_direction;
    assign out_ch.busy_res         = result_reg.busy_res;
    assign out_ch.done_res         = result_reg.done_res;

endmodule

// File: rtl/mpsc_step.sv
// Next-state and result logic for one control tick of the seek controller.
module mpsc_step
    import mpsc_pkg::*;
#(
    parameter int POSITION_BITS = 12
)
(
    input  logic [POSITION_BITS-1:0] meas,
    input  logic [POSITION_BITS-1:0] targ,
    input  cfg_t                     cfg,
    input  seek_state_t              state_cur,
    output seek_state_t              state_next,
    output result_t                  result
);

    localparam int CW = (POSITION_BITS > THRESH_BITS) ? POSITION_BITS : THRESH_BITS;

    logic [POSITION_BITS-1:0] distance;
    logic [CW-1:0]            dist_w;
    logic [CW-1:0]            deadband_w;
    logic [CW-1:0]            far_w;
    logic [CW-1:0]            near_w;
    logic [CW-1:0]            brake_w;
    logic                     meas_lt;
    logic                     meas_gt;
    logic                     done;

    assign meas_lt    = meas < targ;
    assign meas_gt    = meas > targ;
    assign distance   = meas_gt ? (meas - targ) : (targ - meas);
    assign dist_w     = CW'(distance);
    assign deadband_w = CW'(cfg.deadband);
    assign far_w      = CW'(cfg.far_threshold);
    assign near_w     = CW'(cfg.near_threshold);
    assign brake_w    = CW'(cfg.brake_threshold);

    always_comb
    begin
        state_next = state_cur;
        done       = 1'b0;
        case (state_cur.phase)
            PH_IDLE:
            begin
                if (dist_w < deadband_w)
                begin
                    state_next.speed    = '0;
                    state_next.left_on  = 1'b0;
                    state_next.right_on = 1'b0;
                end
                else if (meas != targ)
                begin
                    state_next.speed = (dist_w < far_w) ? cfg.speed_start_slow
                                                        : cfg.speed_fast;
                    if (meas_lt)
                    begin
                        state_next.dir      = DIR_LEFT;
                        state_next.left_on  = 1'b1;
                        state_next.right_on = 1'b0;
                    end
                    else
                    begin
                        state_next.dir      = DIR_RIGHT;
                        state_next.left_on  = 1'b0;
                        state_next.right_on = 1'b1;
                    end
                    state_next.phase = PH_MOVE;
                end
            end
            PH_MOVE:
            begin
                // later tiers override earlier ones; exact thresholds leave speed alone
                if (dist_w > far_w)
                    state_next.speed = cfg.speed_fast;
                if (dist_w < far_w && dist_w > near_w)
                    state_next.speed = cfg.speed_mid;
                if (dist_w < near_w)
                    state_next.speed = cfg.speed_slow;
                // reverse on overshoot
                if (meas_gt && state_cur.dir == DIR_LEFT)
                begin
                    state_next.dir      = DIR_RIGHT;
                    state_next.left_on  = 1'b0;
                    state_next.right_on = 1'b1;
                end
                if (meas_lt && state_cur.dir == DIR_RIGHT)
                begin
                    state_next.dir      = DIR_LEFT;
                    state_next.left_on  = 1'b1;
                    state_next.right_on = 1'b0;
                end
                if (dist_w < brake_w)
                begin
                    state_next.speed    = BRAKE_LEVEL;
                    state_next.left_on  = 1'b1;
                    state_next.right_on = 1'b1;
                    state_next.phase    = PH_SETTLE_A;
                end
            end
            PH_SETTLE_A:
                state_next.phase = PH_SETTLE_B;
            PH_SETTLE_B:
                state_next.phase = PH_SETTLE_C;
            PH_SETTLE_C:
            begin
                state_next.speed    = '0;
                state_next.left_on  = 1'b0;
                state_next.right_on = 1'b0;
                state_next.dir      = DIR_NONE;
                state_next.phase    = PH_IDLE;
                done                = 1'b1;
            end
            default:
                state_next.phase = PH_IDLE;
        endcase
    end

    assign result.compare_value    = COMPARE_BITS'(state_next.speed) * COMPARE_SCALE;
    assign result.left_channel_on  = state_next.left_on;
    assign result.right_channel_on = state_next.right_on;
    assign result.drive_direction  = state_next.dir;
    assign result.busy_res         = (state_next.phase != PH_IDLE);
    assign result.done_res         = done;

endmodule

// File: rtl/mpsc_checker.sv
// Port-level checks of the seek controller, bound to the top level.
`include "motor_position_seek_controller_unit_macros.svh"

module mpsc_checker
    import mpsc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [COMPARE_BITS-1:0] compare_value,
    input logic                    left_channel_on,
    input logic                    right_channel_on,
    input logic [1:0]              drive_direction,
    input logic                    busy_res,
    input logic                    done_res
);

    // a finished settle leaves the drive fully stopped and idle
    `MPSC_ASSERT_NOW(a_done_stops, out_valid && done_res, !busy_res && compare_value == '0 && !left_channel_on && !right_channel_on && drive_direction == DIR_NONE, "done beat with drive not stopped")

    // both channels on only while braking or settling, at brake level
    `MPSC_ASSERT_NOW(a_brake_level, out_valid && left_channel_on && right_channel_on, busy_res && compare_value == BRAKE_COMPARE, "both channels on outside brake")

    // a running channel means a direction has been chosen
    `MPSC_ASSERT_NOW(a_dir_set, out_valid && (left_channel_on || right_channel_on), drive_direction == DIR_LEFT || drive_direction == DIR_RIGHT, "channel on with no direction")

    // a stalled result beat holds
    `MPSC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(compare_value) && $stable(done_res), "stalled result beat changed")

endmodule

bind motor_position_seek_controller_unit mpsc_checker u_mpsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .compare_value    (out_ch.compare_value),
    .left_channel_on  (out_ch.left_channel_on),
    .right_channel_on (out_ch.right_channel_on),
    .drive_direction  (out_ch.drive_direction),
    .busy_res         (out_ch.busy_res),
    .done_res         (out_ch.done_res)
);

// File: tb/sv/testbench.sv
// Self-checking testbench of the seek controller: directed ticks, zero deadband, extreme settings, random seeks.
module testbench;
    import mpsc_pkg::*;

    localparam int POSITION_BITS = 12;
    localparam int POS_MAX       = (1 << POSITION_BITS) - 1;
    localparam int IDLE_PCT      = 16;
    localparam int RANDOM_ITEMS  = 900;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_CYCLES  = 6;

    // Seek phases as the expectation keeps them
    localparam logic [5:0] SEEK_IDLE    = 6'd0;
    localparam logic [5:0] SEEK_MOVING  = 6'd1;
    localparam logic [5:0] SEEK_BRAKE   = 6'd2;
    localparam logic [5:0] SETTLE_LIMIT = 6'd20;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    cfg_idx_t                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    mpsc_in_if #(.POSITION_BITS(POSITION_BITS)) in_ch ();
    mpsc_out_if                                 out_ch ();

    motor_position_seek_controller_unit #(.POSITION_BITS(POSITION_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t                  seek_cfg;
    logic [5:0]            seek_phase;
    dir_t                  seek_dir;
    logic [SPEED_BITS-1:0] seek_speed;
    logic                  seek_left;
    logic                  seek_right;
    result_t               pending_drive[$];
    int unsigned           fault_count;
    int unsigned           ticks_sent;
    bit                    jitter_on;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void steer(input dir_t d);
        seek_dir   = d;
        seek_left  = (d == DIR_LEFT);
        seek_right = (d == DIR_RIGHT);
    endfunction

    function automatic void halt_drive();
        seek_speed = '0;
        seek_left  = 1'b0;
        seek_right = 1'b0;
    endfunction

    // Advance the expected controller state by one tick and return its drive beat.
    function automatic result_t seek_tick(input logic [POSITION_BITS-1:0] meas,
                                          input logic [POSITION_BITS-1:0] targ);
        logic [POSITION_BITS-1:0] distance;
        logic                     settled;
        result_t                  r;
        distance = (meas > targ) ? meas - targ : targ - meas;
        settled  = 1'b0;
        if (seek_phase == SEEK_IDLE)
        begin
            if (distance < seek_cfg.deadband)
                halt_drive();
            else if (meas != targ)
            begin
                seek_speed = (distance < seek_cfg.far_threshold) ? seek_cfg.speed_start_slow
                                                                 : seek_cfg.speed_fast;
                steer((meas < targ) ? DIR_LEFT : DIR_RIGHT);
                seek_phase = SEEK_MOVING;
            end
        end
        else
        begin
            if (seek_phase == SEEK_MOVING)
            begin
                // tiers in order; a later match overrides, exact thresholds keep the speed
                if (distance > seek_cfg.far_threshold)
                    seek_speed = seek_cfg.speed_fast;
                if (distance < seek_cfg.far_threshold && distance > seek_cfg.near_threshold)
                    seek_speed = seek_cfg.speed_mid;
                if (distance < seek_cfg.near_threshold)
                    seek_speed = seek_cfg.speed_slow;
                if (meas > targ && seek_dir == DIR_LEFT)
                    steer(DIR_RIGHT);
                if (meas < targ && seek_dir == DIR_RIGHT)
                    steer(DIR_LEFT);
                if (distance < seek_cfg.brake_threshold)
                begin
                    seek_speed = BRAKE_LEVEL;
                    seek_left  = 1'b1;
                    seek_right = 1'b1;
                    seek_phase = SEEK_BRAKE;
                end
            end
            if (seek_phase >= SEEK_BRAKE)
                seek_phase = seek_phase + seek_phase;
            if (seek_phase > SETTLE_LIMIT)
            begin
                halt_drive();
                seek_phase = SEEK_IDLE;
                seek_dir   = DIR_NONE;
                settled    = 1'b1;
            end
        end
        r.compare_value    = COMPARE_BITS'(seek_speed) * COMPARE_SCALE;
        r.left_channel_on  = seek_left;
        r.right_channel_on = seek_right;
        r.drive_direction  = seek_dir;
        r.busy_res         = (seek_phase != SEEK_IDLE);
        r.done_res         = settled;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // Result side: random stalls, check every accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_drive.size() == 0)
            begin
                $error("drive beat with no expectation waiting");
                fault_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                compare_field("compare_value", 16'(want.compare_value),
                              16'(out_ch.compare_value));
                compare_field("left_channel_on", 16'(want.left_channel_on),
                              16'(out_ch.left_channel_on));
                compare_field("right_channel_on", 16'(want.right_channel_on),
                              16'(out_ch.right_channel_on));
                compare_field("drive_direction", 16'(want.drive_direction),
                              16'(out_ch.drive_direction));
                compare_field("busy_res", 16'(want.busy_res), 16'(out_ch.busy_res));
                compare_field("done_res", 16'(want.done_res), 16'(out_ch.done_res));
            end
        end
        out_ch.ready <= !jitter_on || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_tick(input int meas, input int targ);
        if (jitter_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.measured_position <= meas[POSITION_BITS-1:0];
        in_ch.target_position   <= targ[POSITION_BITS-1:0];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_drive.push_back(seek_tick(meas[POSITION_BITS-1:0], targ[POSITION_BITS-1:0]));
        ticks_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Drain the block, then load all eight registers; junk above the speed bits must be dropped.
    task automatic apply_settings(input cfg_t s);
        in_ch.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_DEADBAND, s.deadband);
        write_reg(REG_FAR, s.far_threshold);
        write_reg(REG_NEAR, s.near_threshold);
        write_reg(REG_BRAKE, s.brake_threshold);
        write_reg(REG_SPD_FAST, {5'($urandom), s.speed_fast});
        write_reg(REG_SPD_START, {5'($urandom), s.speed_start_slow});
        write_reg(REG_SPD_MID, {5'($urandom), s.speed_mid});
        write_reg(REG_SPD_SLOW, {5'($urandom), s.speed_slow});
        cfg_write <= 1'b0;
        seek_cfg = s;
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.speed_fast       = SPEED_BITS'($urandom_range(127));
        s.speed_start_slow = SPEED_BITS'($urandom_range(127));
        s.speed_mid        = SPEED_BITS'($urandom_range(127));
        s.speed_slow       = SPEED_BITS'($urandom_range(127));
        if ($urandom_range(3) == 0)
        begin
            s.deadband        = THRESH_BITS'($urandom_range(POS_MAX));
            s.far_threshold   = THRESH_BITS'($urandom_range(POS_MAX));
            s.near_threshold  = THRESH_BITS'($urandom_range(POS_MAX));
            s.brake_threshold = THRESH_BITS'($urandom_range(POS_MAX));
        end
        else
        begin
            s.deadband        = THRESH_BITS'($urandom_range(80));
            s.brake_threshold = THRESH_BITS'($urandom_range(60, 1));
            s.near_threshold  = THRESH_BITS'($urandom_range(1200, 20));
            s.far_threshold   = THRESH_BITS'($urandom_range(3500, 32'(s.near_threshold)));
        end
        return s;
    endfunction

    // One approach towards a target: start tick, then closing strides with the odd overshoot.
    task automatic run_seek(input int targ, input int start, input int max_ticks);
        int pos;
        int gap;
        int mag;
        int stride;
        int guard;
        pos = start;
        send_tick(pos, targ);
        guard = 0;
        while (seek_phase != SEEK_IDLE && guard < max_ticks)
        begin
            gap = targ - pos;
            mag = (gap < 0) ? -gap : gap;
            if ($urandom_range(7) == 0)
                stride = $urandom_range(mag + mag / 2 + 2);
            else
                stride = $urandom_range(mag, mag / 3);
            pos = (gap < 0) ? pos - stride : pos + stride;
            if (pos < 0)
                pos = 0;
            if (pos > POS_MAX)
                pos = POS_MAX;
            if ($urandom_range(19) == 0)
                targ = $urandom_range(POS_MAX);
            send_tick(pos, targ);
            guard++;
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_tick($urandom_range(POS_MAX), $urandom_range(POS_MAX));
    endtask

    task automatic test_directed_seek();
        send_tick(1000, 1000);
        send_tick(981, 1000);
        send_tick(500, 1000);
        send_tick(600, 1000);
        send_tick(700, 1000);
        send_tick(800, 1000);
        send_tick(900, 1000);
        send_tick(1050, 1000);
        send_tick(1005, 1000);
        repeat (3) send_tick(1000, 1000);
        send_tick(POS_MAX, 0);
        send_tick(0, POS_MAX);
        send_tick(4090, POS_MAX);
        repeat (3) send_tick(0, POS_MAX);
        send_tick(1100, 1000);
        send_tick(1000, 1000);
        repeat (3) send_tick(1000, 1000);
    endtask

    task automatic test_deadband_zero();
        cfg_t s;
        s = seek_cfg;
        s.deadband = '0;
        apply_settings(s);
        send_tick(0, 0);
        send_tick(POS_MAX, POS_MAX);
        send_tick(7, 7);
        send_tick(1, 0);
        send_tick(0, 0);
        repeat (3) send_tick(2048, 2048);
    endtask

    task automatic test_extreme_settings();
        cfg_t s;
        s = '0;
        apply_settings(s);
        send_tick(0, 0);
        send_tick(0, POS_MAX);
        repeat (3) run_seek($urandom_range(POS_MAX), $urandom_range(POS_MAX), 12);
        send_noise(6);
        s = '1;
        apply_settings(s);
        send_tick(100, 200);
        send_tick(0, POS_MAX);
        repeat (4) send_tick(POS_MAX, POS_MAX);
        repeat (3) run_seek($urandom_range(POS_MAX), $urandom_range(POS_MAX), 12);
        send_noise(6);
        // near above far: the slow tier overrides wherever both match
        s = random_settings();
        s.deadband        = 12'd4;
        s.brake_threshold = 12'd8;
        s.far_threshold   = 12'd150;
        s.near_threshold  = 12'd3000;
        apply_settings(s);
        repeat (4) run_seek($urandom_range(POS_MAX), $urandom_range(POS_MAX), 40);
    endtask

    task automatic test_random_seeks();
        cfg_t        s;
        int unsigned stop_at;
        int unsigned phase_end;
        int          round;
        stop_at = ticks_sent + RANDOM_ITEMS;
        round   = 0;
        while (ticks_sent < stop_at)
        begin
            if (round % 4 == 0)
                s = '{DEADBAND_RST, FAR_RST, NEAR_RST, BRAKE_RST,
                      SPD_FAST_RST, SPD_START_RST, SPD_MID_RST, SPD_SLOW_RST};
            else
                s = random_settings();
            apply_settings(s);
            // hold one long stretch free of gaps and stalls
            jitter_on = (round != 3);
            phase_end = ticks_sent + PHASE_ITEMS;
            while (ticks_sent < phase_end && ticks_sent < stop_at)
            begin
                if ($urandom_range(99) < 85)
                    run_seek($urandom_range(POS_MAX), $urandom_range(POS_MAX), 60);
                else
                    send_noise($urandom_range(4, 1));
            end
            round++;
        end
        jitter_on = 1'b1;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_write               = 1'b0;
        cfg_index               = REG_DEADBAND;
        cfg_data                = '0;
        in_ch.valid             = 1'b0;
        in_ch.measured_position = '0;
        in_ch.target_position   = '0;
        out_ch.ready            = 1'b0;
        jitter_on               = 1'b1;
        fault_count             = 0;
        ticks_sent              = 0;
        seek_cfg   = '{DEADBAND_RST, FAR_RST, NEAR_RST, BRAKE_RST,
                       SPD_FAST_RST, SPD_START_RST, SPD_MID_RST, SPD_SLOW_RST};
        seek_phase = SEEK_IDLE;
        seek_dir   = DIR_NONE;
        seek_speed = '0;
        seek_left  = 1'b0;
        seek_right = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_seek();
        test_deadband_zero();
        test_extreme_settings();
        test_random_seeks();

        in_ch.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
